FILE: src/assert_macros.svh
// Assertion macros used by the top-level RTL file.
// Each macro is clocked on i_clk and disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds at every clock edge.
`define ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("assertion failed");

// Checks that a consequent holds in the cycle after an antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: src/krke_pkg.sv
`timescale 1ns / 1ps

package krke_pkg;

    localparam int KEYS_DEF    = 4;
    localparam int INPUT_SLOTS = 4;
    localparam int KEY_W       = 16;
    localparam int COUNT_W     = 3;

    typedef struct packed {
        logic [COUNT_W-1:0] key_count;
        logic [KEY_W-1:0]   key_slot0;
        logic [KEY_W-1:0]   key_slot1;
        logic [KEY_W-1:0]   key_slot2;
        logic [KEY_W-1:0]   key_slot3;
    } t_key_report;

    typedef struct packed {
        logic             is_press;
        logic [KEY_W-1:0] event_key;
        logic             last_event;
    } t_key_event;

    typedef struct packed {
        logic load;
        logic calc;
        logic step;
        logic commit;
    } t_ctrl_cmd;

    typedef struct packed {
        logic present;
        logic mask_empty;
        logic out_free;
    } t_dp_status;

endpackage

FILE: src/krke_ctrl.sv
`timescale 1ns / 1ps

module krke_ctrl
    import krke_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_EMIT
    } t_state;

    t_state r_state;
    logic   r_in_ready;

    always_comb begin
        o_cmd.load   = (r_state == S_IDLE) && i_in_valid && i_status.present;
        o_cmd.calc   = (r_state == S_CALC);
        o_cmd.step   = (r_state == S_EMIT) && !i_status.mask_empty && i_status.out_free;
        o_cmd.commit = (r_state == S_EMIT) && i_status.mask_empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd.load) begin
                        r_state    <= S_CALC;
                        r_in_ready <= 1'b0;
                    end
                end
                S_CALC: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (o_cmd.commit) begin
                        r_state    <= S_IDLE;
                        r_in_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state    <= S_IDLE;
                    r_in_ready <= 1'b1;
                end
            endcase
        end
    end

    assign o_in_ready = r_in_ready;

endmodule

FILE: src/krke_dp.sv
`timescale 1ns / 1ps

module krke_dp
    import krke_pkg::*;
#(
    parameter int KEYS = KEYS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  t_key_report i_in_data,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output t_key_event  o_out_data,
    input  t_ctrl_cmd   i_cmd,
    output t_dp_status  o_status
);

    localparam int SLOTS  = (KEYS > INPUT_SLOTS) ? KEYS : INPUT_SLOTS;
    localparam int MASK_W = 2 * KEYS;

    logic              r_present;
    logic [KEY_W-1:0]  r_fresh [KEYS];
    logic [KEY_W-1:0]  r_prev  [KEYS];
    logic [MASK_W-1:0] r_mask;
    logic              r_out_valid;
    t_key_event        r_out;

    logic [KEY_W-1:0]  w_slot  [SLOTS];
    logic [KEY_W-1:0]  n_fresh [KEYS];
    logic [MASK_W-1:0] n_mask;
    logic [MASK_W-1:0] w_low;
    t_key_event        w_event;
    logic              w_out_free;

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            w_slot[i] = '0;
        end
        w_slot[0] = i_in_data.key_slot0;
        w_slot[1] = i_in_data.key_slot1;
        w_slot[2] = i_in_data.key_slot2;
        w_slot[3] = i_in_data.key_slot3;
        for (int i = 0; i < KEYS; i++) begin
            n_fresh[i] = (i < int'(i_in_data.key_count)) ? w_slot[i] : '0;
        end
    end

    // Slots past the count are stored as zero, so every compare can span all slots.
    always_comb begin
        logic hit_r;
        logic hit_p;
        n_mask = '0;
        for (int i = 0; i < KEYS; i++) begin
            hit_r = 1'b0;
            hit_p = 1'b0;
            for (int j = 0; j < KEYS; j++) begin
                hit_r = hit_r | (r_fresh[j] == r_prev[i]);
                hit_p = hit_p | (r_prev[j] == r_fresh[i]);
            end
            n_mask[i]      = (r_prev[i] != '0) && !hit_r;
            n_mask[KEYS+i] = (r_fresh[i] != '0) && !hit_p;
        end
    end

    always_comb begin
        w_low = r_mask & (~r_mask + MASK_W'(1));
        w_event.is_press   = 1'b0;
        w_event.event_key  = '0;
        w_event.last_event = ((r_mask & ~w_low) == '0);
        for (int j = 0; j < KEYS; j++) begin
            if (w_low[j]) begin
                w_event.event_key = r_prev[j];
            end
            if (w_low[KEYS+j]) begin
                w_event.event_key = r_fresh[j];
                w_event.is_press  = 1'b1;
            end
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present   <= 1'b0;
            r_out_valid <= 1'b0;
            r_mask      <= '0;
            for (int i = 0; i < KEYS; i++) begin
                r_prev[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_present <= i_cfg_wdata;
            end
            if (i_cmd.calc) begin
                r_mask <= n_mask;
            end else if (i_cmd.step) begin
                r_mask <= r_mask & ~w_low;
            end
            if (i_cmd.commit) begin
                for (int i = 0; i < KEYS; i++) begin
                    r_prev[i] <= r_fresh[i];
                end
            end
            if (i_cmd.step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int i = 0; i < KEYS; i++) begin
                r_fresh[i] <= n_fresh[i];
            end
        end
        if (i_cmd.step) begin
            r_out <= w_event;
        end
    end

    assign o_status.present    = r_present;
    assign o_status.mask_empty = (r_mask == '0);
    assign o_status.out_free   = w_out_free;
    assign o_out_valid         = r_out_valid;
    assign o_out_data          = r_out;

endmodule

FILE: src/key_report_to_key_events_top.sv
`timescale 1ns / 1ps
// Turns keyboard reports into key press and release events.
// Input channel (i_in_valid, o_in_ready, i_in_data) takes one report per item.
// Output channel (o_out_valid, i_out_ready, o_out_data) gives one event per item;
// releases come first in old slot order, then presses in new slot order, and the
// final event of a report carries last_event.
// The one-bit configuration register is written through i_cfg_we and i_cfg_wdata.
// While it is 0, reports are accepted one per cycle and dropped without touching the state.
// While the receiver never stalls, the controller loads a report, compares it with the
// stored one, emits one event per cycle and stores the new report before it accepts the
// next one; a report gives at most 2 * KEYS events. The first event is written to the output
// register in the emit state, after the load and compare states. A report with no change yields no item.
// The output register holds an event while the receiver stalls, and the
// emit sequence pauses until it is taken.
// Synchronous reset clears the stored report, the register and the output valid, and sets the input ready.
module key_report_to_key_events_top
    import krke_pkg::*;
#(
    parameter int KEYS = KEYS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_key_report i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_key_event  o_out_data
);

    t_ctrl_cmd  w_cmd;
    t_dp_status w_status;

    krke_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    krke_dp #(
        .KEYS (KEYS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status)
    );

`include "assert_macros.svh"

    `ASSERT_ALWAYS(a_ready_means_drained, !o_in_ready || w_status.mask_empty)
    `ASSERT_ALWAYS(a_step_has_room, !w_cmd.step || w_status.out_free)
    `ASSERT_NEXT(a_load_drops_ready, i_in_valid && o_in_ready && w_status.present, !o_in_ready)

endmodule

FILE: tb/sv/key_report_to_key_events_top_tb.sv
`timescale 1ns / 1ps

module key_report_to_key_events_top_tb;
    import krke_pkg::*;

    localparam int NKEYS         = KEYS_DEF;
    localparam int SETTLE_CYCLES = 2 * NKEYS + 12;
    localparam int LIMIT_CYCLES  = 200000;

    typedef logic [NKEYS-1:0][KEY_W-1:0] t_key_set;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        in_valid  = 1'b0;
    t_key_report in_data   = '0;
    logic        out_ready = 1'b0;
    logic        in_ready;
    logic        out_valid;
    t_key_event  out_data;

    // Predictor state and the queue of key events still to come.
    t_key_set    held_keys     = '0;
    int unsigned held_count    = 0;
    logic        kbd_present   = 1'b0;
    t_key_event  event_q[$];
    t_key_report last_sent     = '0;

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          error_count    = 0;
    int          mismatch_count = 0;
    int unsigned cycle_count    = 0;

    key_report_to_key_events_top i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("[key_report_to_key_events_top] ERROR");
        $finish;
    end

    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic t_key_set slots_of(input t_key_report rep);
        t_key_set s;
        s    = '0;
        s[0] = rep.key_slot0;
        s[1] = rep.key_slot1;
        s[2] = rep.key_slot2;
        s[3] = rep.key_slot3;
        return s;
    endfunction

    function automatic bit holds_key(input t_key_set keys, input int unsigned cnt,
                                     input logic [KEY_W-1:0] code);
        if (code == '0) return 1'b0;
        for (int unsigned i = 0; i < cnt && i < NKEYS; i++) begin
            if (keys[i] == code) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void predict_events(input t_key_report rep);
        t_key_set          incoming;
        t_key_set          fresh;
        int unsigned       cnt;
        int unsigned       old_cnt;
        logic [KEY_W-1:0]  code;
        bit                fires;
        bit                press;
        bit                have_pending;
        t_key_event        pending;
        if (!kbd_present) return;
        cnt      = rep.key_count;
        cnt      = (cnt > NKEYS) ? NKEYS : cnt;
        old_cnt  = (held_count > NKEYS) ? NKEYS : held_count;
        incoming = slots_of(rep);
        fresh    = '0;
        for (int i = 0; i < NKEYS; i++) begin
            if (i < cnt) fresh[i] = incoming[i];
        end
        have_pending = 1'b0;
        pending      = '0;
        // Releases in old slot order, then presses in new slot order.
        for (int j = 0; j < 2 * NKEYS; j++) begin
            if (j < NKEYS) begin
                code  = held_keys[j];
                press = 1'b0;
                fires = (j < old_cnt) && (code != '0) && !holds_key(fresh, cnt, code);
            end else begin
                code  = fresh[j - NKEYS];
                press = 1'b1;
                fires = ((j - NKEYS) < cnt) && (code != '0)
                        && !holds_key(held_keys, old_cnt, code);
            end
            if (fires) begin
                if (have_pending) event_q.push_back(pending);
                pending.is_press   = press;
                pending.event_key  = code;
                pending.last_event = 1'b0;
                have_pending       = 1'b1;
            end
        end
        if (have_pending) begin
            pending.last_event = 1'b1;
            event_q.push_back(pending);
        end
        held_keys  = fresh;
        held_count = cnt;
    endfunction

    always @(posedge clk) begin
        t_key_event want;
        if (rst_n && out_valid && out_ready) begin
            if (event_q.size() == 0) begin
                error_count++;
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected event: press=%0b key=%h last=%0b",
                             out_data.is_press, out_data.event_key, out_data.last_event);
                end
            end else begin
                want = event_q.pop_front();
                if (out_data.is_press !== want.is_press
                        || out_data.event_key !== want.event_key
                        || out_data.last_event !== want.last_event) begin
                    error_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display({"mismatch: expected press=%0b key=%h last=%0b, ",
                                  "got press=%0b key=%h last=%0b"},
                                 want.is_press, want.event_key, want.last_event,
                                 out_data.is_press, out_data.event_key, out_data.last_event);
                    end
                end
            end
        end
    end

    function automatic t_key_report make_report(input logic [COUNT_W-1:0] cnt,
                                                input logic [KEY_W-1:0] s0,
                                                input logic [KEY_W-1:0] s1,
                                                input logic [KEY_W-1:0] s2,
                                                input logic [KEY_W-1:0] s3);
        t_key_report r;
        r.key_count = cnt;
        r.key_slot0 = s0;
        r.key_slot1 = s1;
        r.key_slot2 = s2;
        r.key_slot3 = s3;
        return r;
    endfunction

    // Most reports evolve from the previous one so that keys are held, dropped and added;
    // the rest are fully random noise.
    function automatic t_key_report random_report(input t_key_report prior);
        t_key_set    old_slots;
        t_key_set    new_slots;
        int unsigned cnt;
        int unsigned pick;
        old_slots = slots_of(prior);
        new_slots = '0;
        if ($urandom_range(99) < 20) begin
            cnt = $urandom_range(7);
            for (int i = 0; i < NKEYS; i++) new_slots[i] = KEY_W'($urandom);
        end else begin
            cnt = ($urandom_range(9) < 8) ? $urandom_range(4) : $urandom_range(7, 5);
            for (int i = 0; i < NKEYS; i++) begin
                pick = $urandom_range(99);
                if (i >= cnt) begin
                    new_slots[i] = (pick < 50) ? KEY_W'($urandom) : '0;
                end else if (pick < 50) begin
                    new_slots[i] = old_slots[$urandom_range(NKEYS - 1)];
                end else if (pick < 75) begin
                    new_slots[i] = KEY_W'(16'h0004 + $urandom_range(7));
                end else if (pick < 80) begin
                    new_slots[i] = 16'hFFFF;
                end else if (pick < 88) begin
                    new_slots[i] = '0;
                end else begin
                    new_slots[i] = KEY_W'($urandom);
                end
            end
        end
        return make_report(COUNT_W'(cnt), new_slots[0], new_slots[1],
                           new_slots[2], new_slots[3]);
    endfunction

    task automatic send_report(input t_key_report rep);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= rep;
        do @(posedge clk); while (!in_ready);
        predict_events(rep);
        last_sent = rep;
    endtask

    task automatic await_idle();
        in_valid <= 1'b0;
        while (event_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_keyboard_present(input logic value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        kbd_present = value;
        cfg_we <= 1'b0;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    task automatic test_absent_keyboard();
        send_report(make_report(3'd4, 16'h0004, 16'h0005, 16'h0006, 16'h0007));
        send_report(make_report(3'd7, 16'hFFFF, 16'hAAAA, 16'h5555, 16'h0001));
        for (int i = 0; i < 4; i++) send_report(random_report(last_sent));
        await_idle();
    endtask

    task automatic test_directed_reports();
        send_report(make_report(3'd4, 16'h0004, 16'h0005, 16'h0006, 16'h0007));
        send_report(make_report(3'd4, 16'h0008, 16'h0009, 16'h000A, 16'h000B));
        send_report(make_report(3'd4, 16'h0008, 16'h0009, 16'h000A, 16'h000B));
        send_report(make_report(3'd0, 16'hFFFF, 16'hFFFF, 16'h1234, 16'h4321));
        send_report(make_report(3'd1, 16'hFFFF, 16'h1234, 16'h0000, 16'hFFFF));
        send_report(make_report(3'd2, 16'h0000, 16'hFFFF, 16'h7777, 16'h0000));
        send_report(make_report(3'd3, 16'h0001, 16'h0001, 16'hFFFF, 16'h0001));
        send_report(make_report(3'd1, 16'h0001, 16'hFFFF, 16'hFFFF, 16'h0000));
        send_report(make_report(3'd7, 16'h8000, 16'h4000, 16'h2000, 16'h1000));
        send_report(make_report(3'd5, 16'h8000, 16'h4000, 16'h2000, 16'h1000));
        send_report(make_report(3'd6, 16'h8000, 16'h0000, 16'h2000, 16'hFFFF));
        send_report(make_report(3'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_report(make_report(3'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_report(make_report(3'd4, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_report(make_report(3'd2, 16'hAAAA, 16'h5555, 16'h1111, 16'h2222));
        send_report(make_report(3'd4, 16'h5555, 16'hAAAA, 16'h0000, 16'h0000));
        send_report(make_report(3'd4, 16'h0001, 16'h0002, 16'h0004, 16'h0008));
        send_report(make_report(3'd4, 16'h0008, 16'h0004, 16'h0002, 16'h0001));
        await_idle();
    endtask

    task automatic test_drain_each_report();
        for (int i = 0; i < 8; i++) begin
            send_report(random_report(last_sent));
            await_idle();
        end
    endtask

    task automatic test_present_toggle();
        write_keyboard_present(1'b0);
        for (int i = 0; i < 6; i++) send_report(random_report(last_sent));
        await_idle();
        write_keyboard_present(1'b1);
        for (int i = 0; i < 10; i++) send_report(random_report(last_sent));
        await_idle();
        write_keyboard_present(1'b0);
        write_keyboard_present(1'b1);
        for (int i = 0; i < 5; i++) send_report(random_report(last_sent));
        await_idle();
    endtask

    task automatic test_random_reports(input int count);
        for (int i = 0; i < count; i++) send_report(random_report(last_sent));
        await_idle();
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_idling(0, 0);
        test_absent_keyboard();
        write_keyboard_present(1'b1);
        test_directed_reports();
        set_idling(34, 57);
        test_drain_each_report();
        set_idling(34, 34);
        test_present_toggle();
        set_idling(0, 0);
        test_random_reports(67);
        set_idling(57, 0);
        test_random_reports(67);
        set_idling(0, 57);
        test_random_reports(67);
        set_idling(34, 34);
        test_random_reports(67);
        if (event_q.size() != 0) error_count++;
        if (error_count == 0) begin
            $display("[key_report_to_key_events_top] OK");
        end else begin
            $display("[key_report_to_key_events_top] ERROR");
        end
        $finish;
    end

endmodule
